>>> hdl/assert_macros.svh
// Assertion helpers used by the encoder design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/spoe_pkg.sv
package spoe_pkg;

   // Frame geometry
   localparam int unsigned FRAME_BITS = 48;
   localparam int unsigned BODY_BITS  = 40;   // preamble and four data bytes
   localparam int unsigned CNT_W      = $clog2(FRAME_BITS);

   typedef logic [CNT_W-1:0] cnt_type;

   localparam cnt_type CNT_DATA_FIRST = cnt_type'(8);
   localparam cnt_type CNT_CRC_FIRST  = cnt_type'(BODY_BITS);
   localparam cnt_type CNT_LAST       = cnt_type'(FRAME_BITS - 1);

   // Frame constants
   localparam logic [7:0] PREAMBLE     = 8'hFF;
   localparam logic [7:0] CRC_POLY     = 8'h31;
   localparam logic [7:0] TEMP_MAX_DEG = 8'd204;

   // Register map
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_LOW   = 8'd2;

   localparam logic [15:0] ONE_HIGH_RST  = 16'd500;
   localparam logic [15:0] ZERO_HIGH_RST = 16'd1500;
   localparam logic [15:0] GAP_LOW_RST   = 16'd1000;

   typedef struct packed {
      logic [15:0] one_high;
      logic [15:0] zero_high;
      logic [15:0] gap_low;
   } timing_type;

   // Preamble and data bytes of the frame, MSB of byte zero at the top.
   // Temperature goes out as 12-bit sign-magnitude tenths, sign at bit 11.
   function automatic logic [BODY_BITS-1:0] build_body(
      input logic [7:0] id,
      input logic [8:0] temp_raw,
      input logic [7:0] hum
   );
      logic        neg;
      logic [8:0]  mag9;
      logic [7:0]  mag;
      logic [10:0] tenths;
      logic [11:0] tval;
      neg    = temp_raw[8];
      mag9   = neg ? (~temp_raw + 9'd1) : temp_raw;
      mag    = (mag9 > {1'b0, TEMP_MAX_DEG}) ? TEMP_MAX_DEG : mag9[7:0];
      // times ten as two shifts
      tenths = {mag, 3'b000} + {2'b00, mag, 1'b0};
      tval   = {neg, tenths};
      return {PREAMBLE, 4'h0, id[7:4], id[3:0], tval[11:8], tval[7:0], hum};
   endfunction

endpackage

>>> hdl/spoe_csr.sv
module spoe_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spoe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                       csr_data,
   output spoe_pkg::timing_type              timing
);

   spoe_pkg::timing_type timing_ff, timing_in;

   assign csr_ready = 1'b1;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      timing_in = timing_ff;
      if (csr_valid) begin
         case (csr_index)
            spoe_pkg::CSR_ONE_HIGH:  timing_in.one_high  = csr_data;
            spoe_pkg::CSR_ZERO_HIGH: timing_in.zero_high = csr_data;
            spoe_pkg::CSR_GAP_LOW:   timing_in.gap_low   = csr_data;
            default:                 timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.one_high  <= spoe_pkg::ONE_HIGH_RST;
         timing_ff.zero_high <= spoe_pkg::ZERO_HIGH_RST;
         timing_ff.gap_low   <= spoe_pkg::GAP_LOW_RST;
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign timing = timing_ff;

endmodule

>>> hdl/sensor_packet_ook_encoder.sv
// Sensor reading to on-off-keyed pulse train. Each reading beat (id,
// temperature, humidity) becomes a 48-bit frame - preamble, id, saturated
// temperature in tenths, humidity, CRC-8 (poly 0x31) - sent MSB first as 48
// response beats of (bit, high time, low time), tlast on the final one. The
// bit shifter emits one pulse per cycle while rsp_tready does not hold the
// output; one further reading is held in the input register, and the next
// frame starts in the cycle after the previous frame's last pulse. The first
// pulse reaches the output through the input register, the bit shifter and
// the output register. The CRC is formed bit by bit as the data bits shift
// out. Timing registers are sampled as each pulse leaves the shifter, so
// they should only be written while the block is idle.
`include "assert_macros.svh"

module sensor_packet_ook_encoder (
   input  logic                              clock,
   input  logic                              reset,
   // reading channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // sensor_id[7:0],
                                                         // temperature_deg[16:8],
                                                         // humidity_pct[24:17], pad
   // pulse channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,  // bit_value[0],
                                                         // high_time_us[16:1],
                                                         // low_time_us[32:17], pad
   output logic                              rsp_tlast,  // last_bit
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spoe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                       csr_data
);

   spoe_pkg::timing_type timing;

   spoe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .timing    (timing)
   );

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_id_ff;
   logic signed [8:0] in_temp_ff;
   logic [7:0]        in_hum_ff;

   // Bit shifter
   logic                                sh_active_ff, sh_active_in;
   spoe_pkg::cnt_type                   sh_cnt_ff, sh_cnt_in;
   logic [spoe_pkg::BODY_BITS-1:0]      sh_body_ff, sh_body_in;
   logic [7:0]                          sh_crc_ff, sh_crc_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_bit_ff, rsp_bit_in;
   logic [15:0] rsp_high_ff, rsp_high_in;
   logic [15:0] rsp_low_ff, rsp_low_in;
   logic        rsp_last_ff, rsp_last_in;

   logic req_beat;
   logic advance;
   logic frame_done;
   logic load;
   logic tx_bit;
   logic crc_fb;

   assign req_beat   = req_tvalid && req_tready;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign frame_done = sh_active_ff && advance && (sh_cnt_ff == spoe_pkg::CNT_LAST);
   assign load       = in_valid_ff && (!sh_active_ff || frame_done);
   assign req_tready = !in_valid_ff || load;

   // Input register: holds one reading while the shifter is busy
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_id_ff   <= req_tdata[7:0];
         in_temp_ff <= signed'(req_tdata[16:8]);
         in_hum_ff  <= req_tdata[24:17];
      end
   end

   // Bit source: body bits first, then the CRC byte
   assign tx_bit = (sh_cnt_ff < spoe_pkg::CNT_CRC_FIRST) ? sh_body_ff[spoe_pkg::BODY_BITS-1]
                                                          : sh_crc_ff[7];
   assign crc_fb = sh_crc_ff[7] ^ sh_body_ff[spoe_pkg::BODY_BITS-1];

   // Shifter: one bit per accepted output slot, CRC runs over bytes 1..4
   always_comb begin
      sh_active_in = sh_active_ff;
      sh_cnt_in    = sh_cnt_ff;
      sh_body_in   = sh_body_ff;
      sh_crc_in    = sh_crc_ff;
      if (sh_active_ff && advance) begin
         sh_cnt_in  = sh_cnt_ff + spoe_pkg::cnt_type'(1);
         sh_body_in = {sh_body_ff[spoe_pkg::BODY_BITS-2:0], 1'b0};
         if (sh_cnt_ff >= spoe_pkg::CNT_CRC_FIRST) begin
            sh_crc_in = {sh_crc_ff[6:0], 1'b0};
         end else if (sh_cnt_ff >= spoe_pkg::CNT_DATA_FIRST) begin
            sh_crc_in = {sh_crc_ff[6:0], 1'b0} ^ (crc_fb ? spoe_pkg::CRC_POLY : 8'h00);
         end
         if (frame_done) begin
            sh_active_in = 1'b0;
         end
      end
      if (load) begin
         sh_active_in = 1'b1;
         sh_cnt_in    = '0;
         sh_crc_in    = 8'h00;
         sh_body_in   = spoe_pkg::build_body(in_id_ff, unsigned'(in_temp_ff), in_hum_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_active_ff <= 1'b0;
         sh_cnt_ff    <= '0;
      end else begin
         sh_active_ff <= sh_active_in;
         sh_cnt_ff    <= sh_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_body_ff <= sh_body_in;
      sh_crc_ff  <= sh_crc_in;
   end

   // Output register: pulse beat with its timings
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = sh_active_ff;
         rsp_bit_in   = tx_bit;
         rsp_high_in  = tx_bit ? timing.one_high : timing.zero_high;
         rsp_low_in   = timing.gap_low;
         rsp_last_in  = (sh_cnt_ff == spoe_pkg::CNT_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bit_ff  <= rsp_bit_in;
      rsp_high_ff <= rsp_high_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_low_ff, rsp_high_ff, rsp_bit_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `ASSERT_NEVER(a_cnt_range, clock, reset, sh_active_ff && (sh_cnt_ff > spoe_pkg::CNT_LAST), "bit count past frame end")
   `ASSERT_ALWAYS(a_load_starts, clock, reset, load |=> (sh_active_ff && (sh_cnt_ff == '0)), "frame load did not restart the shifter")
   `ASSERT_ALWAYS(a_last_flag, clock, reset, frame_done |=> (rsp_valid_ff && rsp_last_ff), "final pulse not flagged")
   `ASSERT_NEVER(a_last_early, clock, reset, sh_active_ff && advance && (sh_cnt_ff != spoe_pkg::CNT_LAST) && rsp_last_in, "pulse flagged last too early")

endmodule
